FILE: rtl/core/bfr_pkg.sv
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared types, codes and CRC helpers for the beacon frame receiver.
// ----------------------------------------------------------------------------
package bfr_pkg;

    localparam logic [7:0] CRC_POLY     = 8'h07;
    localparam logic [7:0] HDR_LEGACY_0 = 8'hAA;
    localparam logic [7:0] HDR_LEGACY_1 = 8'h55;
    localparam logic [7:0] HDR_V2       = 8'hBD;
    localparam logic [7:0] ACK_V2_HDR   = 8'hBE;
    localparam logic [7:0] FRAME_VER    = 8'h02;
    localparam logic [7:0] ACK_LEGACY   = 8'hCC;
    localparam logic [15:0] TIMEOUT_RESET = 16'd300;
    localparam logic [7:0] LEGACY_ID_MAX = 8'd31;
    localparam logic [7:0] V2_STATE_MAX  = 8'd15;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        JOB_NONE,
        JOB_LEGACY,
        JOB_V2
    } t_job_kind;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_VERSION,
        ST_BAD_STATE,
        ST_BAD_CRC
    } t_v2_status;

    typedef struct packed {
        t_job_kind  kind;
        logic [5:0] led;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
    } t_job;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
        logic [7:0] c;
        c = crc_in ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic parity4(input logic [3:0] v);
        return ^v;
    endfunction

    localparam logic [7:0] ACK_CRC_SEED = crc8_byte(crc8_byte(8'h00, ACK_V2_HDR), FRAME_VER);

endpackage

FILE: rtl/core/bfr_front.sv
// ----------------------------------------------------------------------------
// bfr_front
// Frame assembly, checking, LED and watchdog state; emits one job per item.
// ----------------------------------------------------------------------------
module bfr_front import bfr_pkg::*; #(
    parameter int ELAPSED_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_q_full,
    output logic        o_push,
    output t_job        o_job
);

    localparam int CW = (ELAPSED_BITS > 16) ? ELAPSED_BITS : 16;

    logic [15:0]             r_timeout;
    logic [2:0]              r_pos,   n_pos;
    logic                    r_v2,    n_v2;
    logic [7:0]              r_crc,   n_crc;
    logic [7:0]              r_ack,   n_ack;
    logic [5:0]              r_led,   n_led;
    logic                    r_armed, n_armed;
    logic [ELAPSED_BITS-1:0] r_el,    n_el;
    logic [7:0]              r_fb [4];
    logic                    fb_we;
    logic [1:0]              fb_idx;
    logic [7:0]              b;
    logic [7:0]              id, seq, br, st, ctr;
    logic                    leg_ok;
    t_v2_status              status;
    logic [2:0]              d;
    logic                    s;

    assign o_in_ready  = !i_q_full;
    assign o_cfg_ready = 1'b1;
    assign o_push      = i_in_valid && o_in_ready;
    assign fb_idx      = 2'(r_pos - 3'd1);

    always_comb begin
        b       = i_rx_byte;
        id      = r_fb[1];
        seq     = r_fb[2];
        br      = r_fb[3];
        st      = r_fb[1];
        ctr     = r_fb[2];
        leg_ok  = (id <= LEGACY_ID_MAX) && (seq <= 8'd1) && (b == (id ^ seq ^ br));
        d       = id[2:0];
        s       = seq[0];
        status  = ST_OK;
        if (r_fb[0] != FRAME_VER) begin
            status = ST_BAD_VERSION;
        end else if (st > V2_STATE_MAX) begin
            status = ST_BAD_STATE;
        end else if (b != r_crc) begin
            status = ST_BAD_CRC;
        end

        n_pos   = r_pos;
        n_v2    = r_v2;
        n_crc   = r_crc;
        n_ack   = r_ack;
        n_led   = r_led;
        n_armed = r_armed;
        n_el    = r_el;
        fb_we   = 1'b0;
        o_job   = '{kind: JOB_NONE, led: 6'd0, b0: 8'd0, b1: 8'd0, b2: 8'd0, b3: 8'd0};

        if (o_push) begin
            if (!i_cmd) begin
                priority if (r_pos == 3'd0 || r_pos > 3'd5) begin
                    n_pos = 3'd0;
                    if (b == HDR_LEGACY_0 || b == HDR_V2) begin
                        n_v2  = (b == HDR_V2);
                        n_crc = crc8_byte(8'h00, b);
                        n_pos = 3'd1;
                    end
                end else if (r_pos == 3'd1 && !r_v2 && b != HDR_LEGACY_1) begin
                    n_pos = 3'd0;
                    if (b == HDR_LEGACY_0 || b == HDR_V2) begin
                        n_v2  = (b == HDR_V2);
                        n_crc = crc8_byte(8'h00, b);
                        n_pos = 3'd1;
                    end
                end else if (r_pos < 3'd5) begin
                    fb_we = 1'b1;
                    n_crc = crc8_byte(r_crc, b);
                    n_pos = r_pos + 3'd1;
                    if (r_pos == 3'd2) begin
                        n_ack = crc8_byte(ACK_CRC_SEED, b);
                    end else if (r_pos == 3'd3) begin
                        n_ack = crc8_byte(r_ack, b);
                    end
                end else begin
                    n_pos = 3'd0;
                    if (r_v2) begin
                        if (status == ST_OK) begin
                            n_led   = {parity4(st[3:0]), 1'b1, st[3:0]};
                            n_el    = '0;
                            n_armed = 1'b1;
                        end
                        o_job.kind = JOB_V2;
                        o_job.b0   = st;
                        o_job.b1   = ctr;
                        o_job.b2   = {6'd0, status};
                        o_job.b3   = crc8_byte(r_ack, {6'd0, status});
                    end else if (leg_ok) begin
                        n_led      = {parity4({s, d}), s, (id != 8'd0), d};
                        o_job.kind = JOB_LEGACY;
                        o_job.b0   = id;
                        o_job.b1   = seq;
                    end
                end
            end else if (r_armed) begin
                if (r_el != '1) begin
                    n_el = r_el + 1'b1;
                end
                if (CW'(n_el) > CW'(r_timeout)) begin
                    n_led   = 6'd0;
                    n_armed = 1'b0;
                end
            end
        end
        o_job.led = n_led;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
            r_pos     <= 3'd0;
            r_v2      <= 1'b0;
            r_crc     <= 8'd0;
            r_ack     <= 8'd0;
            r_led     <= 6'd0;
            r_armed   <= 1'b0;
            r_el      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end
            r_pos   <= n_pos;
            r_v2    <= n_v2;
            r_crc   <= n_crc;
            r_ack   <= n_ack;
            r_led   <= n_led;
            r_armed <= n_armed;
            r_el    <= n_el;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fb_we) begin
            r_fb[fb_idx] <= b;
        end
    end

endmodule

FILE: rtl/core/bfr_queue.sv
// ----------------------------------------------------------------------------
// bfr_queue
// Short job queue between the frame front end and the result sequencer.
// ----------------------------------------------------------------------------
module bfr_queue import bfr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

FILE: rtl/core/bfr_back.sv
// ----------------------------------------------------------------------------
// bfr_back
// Result sequencer: expands one queued job into its acknowledge transactions.
// ----------------------------------------------------------------------------
module bfr_back import bfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_job       i_head,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic [5:0] o_led_mask,
    output logic       o_last
);

    logic [2:0] r_beat;
    logic [2:0] last_beat;
    logic       fire;

    assign o_out_valid = !i_empty;
    assign fire        = o_out_valid && i_out_ready;
    assign o_last      = (r_beat == last_beat);
    assign o_pop       = fire && o_last;
    assign o_led_mask  = i_head.led;
    assign o_tx_valid  = (i_head.kind != JOB_NONE);

    always_comb begin
        last_beat = 3'd0;
        o_tx_byte = 8'd0;
        unique case (i_head.kind)
            JOB_LEGACY: begin
                last_beat = 3'd2;
                unique case (r_beat)
                    3'd0:    o_tx_byte = ACK_LEGACY;
                    3'd1:    o_tx_byte = i_head.b0;
                    default: o_tx_byte = i_head.b1;
                endcase
            end
            JOB_V2: begin
                last_beat = 3'd5;
                unique case (r_beat)
                    3'd0:    o_tx_byte = ACK_V2_HDR;
                    3'd1:    o_tx_byte = FRAME_VER;
                    3'd2:    o_tx_byte = i_head.b0;
                    3'd3:    o_tx_byte = i_head.b1;
                    3'd4:    o_tx_byte = i_head.b2;
                    default: o_tx_byte = i_head.b3;
                endcase
            end
            default: begin
                last_beat = 3'd0;
                o_tx_byte = 8'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= 3'd0;
        end else if (fire) begin
            r_beat <= o_last ? 3'd0 : r_beat + 3'd1;
        end
    end

endmodule

FILE: rtl/core/beacon_frame_receiver.sv
// ----------------------------------------------------------------------------
// beacon_frame_receiver
// Receives serial bytes and millisecond ticks, assembles legacy and V2 beacon
// frames, drives six LEDs and produces acknowledge bytes.
//
// Input channel (i_in_valid/o_in_ready): one transaction per byte or tick,
// i_cmd 0 for a byte in i_rx_byte, 1 for a tick. One transaction per cycle
// is taken while the internal job queue (4 entries) has room.
// Output channel (o_out_valid/i_out_ready): every input transaction yields
// 1, 3 (legacy ack) or 6 (V2 ack) output transactions, one per cycle while
// i_out_ready is high, o_last marking the final one. Each job is written
// into the job queue before its first result is visible. Sustained rate
// is set by the result sequencer: one transaction per cycle while ready.
// Config channel (i_cfg_valid/o_cfg_ready): writes the 16-bit tick timeout,
// always ready; write only while idle.
// Reset: frame state, LEDs and watchdog clear, queue empties, timeout 300.
// Stall: when the receiver holds i_out_ready low, jobs collect in the queue
// and o_in_ready drops once it is full.
// ----------------------------------------------------------------------------
module beacon_frame_receiver import bfr_pkg::*; #(
    parameter int ELAPSED_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic [5:0]  o_led_mask,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic q_full, q_empty, push, pop;
    t_job job, head;

    bfr_front #(.ELAPSED_BITS(ELAPSED_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_cmd      (i_cmd),
        .i_rx_byte  (i_rx_byte),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (job)
    );

    bfr_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (job),
        .i_pop  (pop),
        .o_full (q_full),
        .o_empty(q_empty),
        .o_head (head)
    );

    bfr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_head     (head),
        .o_pop      (pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_tx_valid (o_tx_valid),
        .o_tx_byte  (o_tx_byte),
        .o_led_mask (o_led_mask),
        .o_last     (o_last)
    );

endmodule

FILE: dv/beacon_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// beacon_frame_receiver_tb
// Self-checking bench for the beacon frame receiver. Drives bytes and ticks,
// predicts every acknowledge transaction and the LED mask, and compares each
// result field by field. Covers legacy and V2 frames, their error cases,
// resync and timeouts, including zero and maximum tick limits, under
// random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import bfr_pkg::*;

typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [5:0] led;
    logic       last;
} t_ack_beat;

function automatic logic [7:0] crc8_atm_next(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
        fb = r[7] ^ b[i];
        r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
endfunction

class beacon_scoreboard #(int ELAPSED_BITS = 16);
    t_ack_beat               expected_q[$];
    int                      errors;
    int                      n_results;
    logic [15:0]             timeout_ticks;
    logic [2:0]              byte_slot;
    logic                    is_v2;
    logic [7:0]              body[4];
    logic [7:0]              frame_crc;
    logic [5:0]              led_drive;
    logic                    armed;
    logic [ELAPSED_BITS-1:0] elapsed;
    logic [7:0]              ack_bytes[$];

    function new();
        errors        = 0;
        n_results     = 0;
        timeout_ticks = TIMEOUT_RESET;
        byte_slot     = 3'd0;
        is_v2         = 1'b0;
        foreach (body[i]) body[i] = 8'h00;
        frame_crc     = 8'h00;
        led_drive     = 6'd0;
        armed         = 1'b0;
        elapsed       = '0;
    endfunction

    function void set_timeout(input logic [15:0] value);
        timeout_ticks = value;
    endfunction

    function void open_frame(input logic [7:0] b);
        is_v2     = (b == HDR_V2);
        frame_crc = crc8_atm_next(8'h00, b);
        byte_slot = 3'd1;
    endfunction

    function void close_legacy(input logic [7:0] chk);
        logic [7:0] id;
        logic [7:0] seq;
        logic [7:0] bright;
        id     = body[1];
        seq    = body[2];
        bright = body[3];
        if (id > LEGACY_ID_MAX || seq > 8'd1 || chk != (id ^ seq ^ bright)) return;
        led_drive = {^{id[2:0], seq[0]}, seq[0], id != 8'h00, id[2:0]};
        ack_bytes.push_back(ACK_LEGACY);
        ack_bytes.push_back(id);
        ack_bytes.push_back(seq);
    endfunction

    function void close_v2(input logic [7:0] chk);
        t_v2_status status;
        logic [7:0] st;
        logic [7:0] ack_crc;
        st = body[1];
        if (body[0] != FRAME_VER) begin
            status = ST_BAD_VERSION;
        end else if (st > V2_STATE_MAX) begin
            status = ST_BAD_STATE;
        end else if (chk != frame_crc) begin
            status = ST_BAD_CRC;
        end else begin
            status = ST_OK;
        end
        if (status == ST_OK) begin
            led_drive = {^st[3:0], 1'b1, st[3:0]};
            elapsed   = '0;
            armed     = 1'b1;
        end
        ack_bytes.push_back(ACK_V2_HDR);
        ack_bytes.push_back(FRAME_VER);
        ack_bytes.push_back(st);
        ack_bytes.push_back(body[2]);
        ack_bytes.push_back(8'(status));
        ack_crc = 8'h00;
        foreach (ack_bytes[i]) ack_crc = crc8_atm_next(ack_crc, ack_bytes[i]);
        ack_bytes.push_back(ack_crc);
    endfunction

    function void note_item(input logic cmd, input logic [7:0] b);
        t_ack_beat beat;
        ack_bytes.delete();
        if (cmd) begin
            if (armed) begin
                if (elapsed != '1) elapsed++;
                if (elapsed > timeout_ticks) begin
                    led_drive = 6'd0;
                    armed     = 1'b0;
                end
            end
        end else if (byte_slot == 3'd0 || byte_slot > 3'd5) begin
            byte_slot = 3'd0;
            if (b == HDR_LEGACY_0 || b == HDR_V2) open_frame(b);
        end else if (byte_slot == 3'd1 && !is_v2 && b != HDR_LEGACY_1) begin
            if (b == HDR_LEGACY_0 || b == HDR_V2) begin
                open_frame(b);
            end else begin
                byte_slot = 3'd0;
            end
        end else if (byte_slot < 3'd5) begin
            body[2'(byte_slot - 3'd1)] = b;
            frame_crc = crc8_atm_next(frame_crc, b);
            byte_slot++;
        end else begin
            if (is_v2) begin
                close_v2(b);
            end else begin
                close_legacy(b);
            end
            byte_slot = 3'd0;
        end
        if (ack_bytes.size() == 0) begin
            beat = '{tx_valid: 1'b0, tx_byte: 8'h00, led: led_drive, last: 1'b1};
            expected_q.push_back(beat);
        end else begin
            foreach (ack_bytes[i]) begin
                beat.tx_valid = 1'b1;
                beat.tx_byte  = ack_bytes[i];
                beat.led      = led_drive;
                beat.last     = (i == ack_bytes.size() - 1);
                expected_q.push_back(beat);
            end
        end
    endfunction

    task report(input string msg);
        errors++;
        $display("%0t MISMATCH result %0d: %s", $time, n_results, msg);
    endtask

    task check_result(input logic txv, input logic [7:0] txb, input logic [5:0] led,
                      input logic last);
        t_ack_beat exp_beat;
        n_results++;
        if (expected_q.size() == 0) begin
            report($sformatf("no transaction expected, got tx_valid=%0b tx_byte=%02h",
                             txv, txb));
            return;
        end
        exp_beat = expected_q.pop_front();
        if (txv !== exp_beat.tx_valid)
            report($sformatf("tx_valid %0b, expected %0b", txv, exp_beat.tx_valid));
        if (txb !== exp_beat.tx_byte)
            report($sformatf("tx_byte %02h, expected %02h", txb, exp_beat.tx_byte));
        if (led !== exp_beat.led)
            report($sformatf("led_mask %02h, expected %02h", led, exp_beat.led));
        if (last !== exp_beat.last)
            report($sformatf("last %0b, expected %0b", last, exp_beat.last));
    endtask
endclass

module beacon_frame_receiver_tb;

    localparam int ELAPSED_BITS = 16;
    localparam int CLK_PERIOD   = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_TAIL   = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_cmd;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_tx_valid;
    logic [7:0]  o_tx_byte;
    logic [5:0]  o_led_mask;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    int src_idle_pct;
    int sink_idle_pct;
    int tick_mix_pct;
    int hold_reqs;
    int items_sent;

    beacon_scoreboard #(ELAPSED_BITS) sb;

    beacon_frame_receiver #(
        .ELAPSED_BITS(ELAPSED_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_tx_valid  (o_tx_valid),
        .o_tx_byte   (o_tx_byte),
        .o_led_mask  (o_led_mask),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_result(o_tx_valid, o_tx_byte, o_led_mask, o_last);
            if (i_in_valid && o_in_ready) sb.note_item(i_cmd, i_rx_byte);
            if (i_cfg_valid && o_cfg_ready) sb.set_timeout(i_cfg_data);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("beacon_frame_receiver regression: fail");
        $finish;
    end

    initial begin : result_sink
        int hold_left;
        int holds_done;
        hold_left   = 0;
        holds_done  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_done != hold_reqs) begin
                holds_done = hold_reqs;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else begin
                i_out_ready = ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic cmd, input logic [7:0] data);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_cmd      = cmd;
        i_rx_byte  = data;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] data);
        if ($urandom_range(99) < tick_mix_pct) send_item(1'b1, 8'($urandom));
        send_item(1'b0, data);
    endtask

    task automatic send_legacy(input logic [7:0] id, seq, bright, chk_flip);
        send_byte(HDR_LEGACY_0);
        send_byte(HDR_LEGACY_1);
        send_byte(id);
        send_byte(seq);
        send_byte(bright);
        send_byte(id ^ seq ^ bright ^ chk_flip);
    endtask

    task automatic send_v2(input logic [7:0] ver, st, ctr, bright, crc_flip);
        logic [7:0] c;
        c = crc8_atm_next(8'h00, HDR_V2);
        c = crc8_atm_next(c, ver);
        c = crc8_atm_next(c, st);
        c = crc8_atm_next(c, ctr);
        c = crc8_atm_next(c, bright);
        send_byte(HDR_V2);
        send_byte(ver);
        send_byte(st);
        send_byte(ctr);
        send_byte(bright);
        send_byte(c ^ crc_flip);
    endtask

    task automatic send_mixed_traffic(input int item_goal);
        int         pick;
        logic [7:0] a;
        logic [7:0] b;
        while (items_sent < item_goal) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                a = ($urandom_range(9) == 0) ? 8'($urandom) : FRAME_VER;
                b = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(15));
                send_v2(a, b, 8'($urandom), 8'($urandom),
                        ($urandom_range(7) == 0) ? 8'($urandom_range(255, 1)) : 8'h00);
            end else if (pick < 70) begin
                a = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(31));
                b = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(1));
                send_legacy(a, b, 8'($urandom),
                            ($urandom_range(7) == 0) ? 8'($urandom_range(255, 1)) : 8'h00);
            end else if (pick < 85) begin
                repeat ($urandom_range(16, 1)) send_item(1'b1, 8'($urandom));
            end else begin
                repeat ($urandom_range(4, 1)) begin
                    case ($urandom_range(3))
                        0:       a = HDR_LEGACY_0;
                        1:       a = HDR_V2;
                        2:       a = HDR_LEGACY_1;
                        default: a = 8'($urandom);
                    endcase
                    send_item(1'b0, a);
                end
            end
        end
    endtask

    // hold the input until every result is back, then let the block settle
    task automatic drain();
        i_in_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin : stimulus
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_cmd         = 1'b0;
        i_rx_byte     = 8'h00;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 16'h0000;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        tick_mix_pct  = 0;
        hold_reqs     = 0;
        items_sent    = 0;
        sb            = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        src_idle_pct  = 32;
        sink_idle_pct = 63;
        write_timeout(16'd3);
        send_legacy(LEGACY_ID_MAX, 8'd1, 8'hFF, 8'h00);
        // dangling legacy header, resync onto V2
        send_item(1'b0, HDR_LEGACY_0);
        send_v2(FRAME_VER, V2_STATE_MAX, 8'hFF, 8'h00, 8'h00);
        // legacy frame while the V2 watchdog stays armed
        send_legacy(8'd0, 8'd0, 8'h00, 8'h00);
        repeat (4) send_item(1'b1, 8'hFF);
        tick_mix_pct = 5;
        send_mixed_traffic(100);

        drain();
        src_idle_pct  = 63;
        sink_idle_pct = 32;
        write_timeout(16'd0);
        send_mixed_traffic(190);

        drain();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_timeout(16'd12);
        hold_reqs++;
        send_mixed_traffic(240);
        drain();
        send_mixed_traffic(265);

        // hold the LEDs through a run of ticks at the largest limit, then lower it
        drain();
        tick_mix_pct = 0;
        write_timeout(16'hFFFF);
        send_v2(FRAME_VER, 8'd9, 8'h5A, 8'hC3, 8'h00);
        repeat (8) send_item(1'b1, 8'($urandom));
        drain();
        write_timeout(16'd1);
        repeat (3) send_item(1'b1, 8'($urandom));

        drain();
        if (sb.errors == 0) begin
            $display("beacon_frame_receiver regression: pass");
        end else begin
            $display("beacon_frame_receiver regression: fail");
        end
        $finish;
    end

endmodule

FILE: beacon_frame_receiver.f
rtl/core/bfr_pkg.sv
rtl/core/bfr_front.sv
rtl/core/bfr_queue.sv
rtl/core/bfr_back.sv
rtl/core/beacon_frame_receiver.sv
dv/beacon_frame_receiver_tb.sv
